// File: rtl/text_terminal_with_scrollback_core_macros.svh
// Assertion macros for the text terminal core checker.
// Both macros clock on clk and are disabled while arst_n is low.
`ifndef TEXT_TERMINAL_WITH_SCROLLBACK_CORE_MACROS_SVH
`define TEXT_TERMINAL_WITH_SCROLLBACK_CORE_MACROS_SVH

// same-cycle implication
`define TTS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tts_pkg.sv
// Shared constants, types and address helpers of the text terminal core.
// No dependencies.
`default_nettype none
package tts_pkg;

	localparam int SCREEN_WIDTH  = 80;
	localparam int SCREEN_HEIGHT = 25;
	localparam int HISTORY_LINES = 100;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int OFF_W  = 7;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	localparam int SCR_DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int HIST_DEPTH = SCREEN_WIDTH * HISTORY_LINES;
	localparam int SCR_AW     = $clog2(SCR_DEPTH);
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int CNT_W      = $clog2(HISTORY_LINES + 1);
	localparam int MOD_W      = $clog2(HISTORY_LINES + SCREEN_HEIGHT);

	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
	localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;
	localparam logic [CELL_W-1:0] CELL_RESET = 16'h0720;
	localparam logic [7:0]        COLOR_RESET = 8'd7;

	typedef enum logic [3:0] {
		OP_PUT       = 4'd0,
		OP_OVERWRITE = 4'd1,
		OP_DELETE    = 4'd2,
		OP_MOVE      = 4'd3,
		OP_LEFT      = 4'd4,
		OP_RIGHT     = 4'd5,
		OP_SCROLL_UP = 4'd6,
		OP_SCROLL_DN = 4'd7,
		OP_READ      = 4'd8
	} op_t;

	function automatic logic [SCR_AW-1:0] scr_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		scr_addr = SCR_AW'(int'(row) * SCREEN_WIDTH + int'(col));
	endfunction

	function automatic logic [HIST_AW-1:0] hist_addr(input logic [MOD_W-1:0] line,
			input logic [COL_W-1:0] col);
		hist_addr = HIST_AW'(int'(line) * SCREEN_WIDTH + int'(col));
	endfunction

endpackage
`default_nettype wire

// File: rtl/tts_if.sv
// Command and response channel interfaces of the text terminal core.
// Depends on tts_pkg for field widths.
`default_nettype none
interface tts_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [3:0]                     op;
	logic [tts_pkg::CHAR_W-1:0]     ch;
	logic [tts_pkg::ROW_W-1:0]      target_row;
	logic [tts_pkg::COL_W-1:0]      target_column;
	modport source (output valid, op, ch, target_row, target_column, input ready);
	modport sink (input valid, op, ch, target_row, target_column, output ready);
endinterface

interface tts_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [tts_pkg::ROW_W-1:0]      cursor_row;
	logic [tts_pkg::COL_W-1:0]      cursor_column;
	logic [tts_pkg::OFF_W-1:0]      view_offset;
	logic [tts_pkg::CELL_W-1:0]     cell_value;
	modport source (output valid, cursor_row, cursor_column, view_offset, cell_value,
		input ready);
	modport sink (input valid, cursor_row, cursor_column, view_offset, cell_value,
		output ready);
endinterface
`default_nettype wire

// File: rtl/text_terminal_with_scrollback_core.sv
// Text terminal engine: screen memory, scrollback ring and command sequencer.
// Depends on tts_pkg and the channel interfaces in tts_if.sv.
`default_nettype none
// Takes one command word at a time and returns one response word for each. After reset the
// screen memory is cleared to blank cells, one cell a cycle, before the first command is
// taken. An inserted character shifts the rest of its row right and carries the pushed-off
// character into the next row, until a blank is pushed off or the bottom row is reached.
// A newline or wrap off the bottom row scrolls the screen. The screen memory has a single
// read and a single write port. A finished response waits in an output register, so the
// next command is taken while it is still pending.
module text_terminal_with_scrollback_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	tts_cmd_if.sink         cmd,
	tts_rsp_if.source       rsp,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_OVR,
		S_INS_PEEK, S_INS_CAP, S_INS_RD, S_INS_WR, S_ADV,
		S_HIST_RD, S_HIST_WR, S_MV_RD, S_MV_WR, S_BLANK,
		S_DEL_RD, S_DEL_WR,
		S_RD_K, S_RD_START, S_RD_SEL, S_RD_MOD, S_RD_WAIT,
		S_DONE
	} state_t;

	localparam int W = tts_pkg::SCREEN_WIDTH;
	localparam int H = tts_pkg::SCREEN_HEIGHT;
	localparam int HL = tts_pkg::HISTORY_LINES;

	state_t state_q;
	logic [tts_pkg::ROW_W-1:0]  cur_row_q, y_q, tr_q;
	logic [tts_pkg::COL_W-1:0]  cur_col_q, x_q, i_q, tc_q;
	logic [tts_pkg::CNT_W-1:0]  sb_q, hcnt_q, hwl_q, k_q, start_q;
	logic [tts_pkg::MOD_W-1:0]  mod_q;
	logic [tts_pkg::CHAR_W-1:0] c_q, pushed_q;
	logic [7:0]                 color_q;
	logic [tts_pkg::SCR_AW-1:0] idx_q;
	logic [tts_pkg::CELL_W-1:0] cell_q;
	logic                       rd_hist_q;

	logic                       rsp_valid_q;
	logic [tts_pkg::ROW_W-1:0]  rsp_row_q;
	logic [tts_pkg::COL_W-1:0]  rsp_col_q;
	logic [tts_pkg::OFF_W-1:0]  rsp_off_q;
	logic [tts_pkg::CELL_W-1:0] rsp_cell_q;

	logic [tts_pkg::CELL_W-1:0]  scr_mem [tts_pkg::SCR_DEPTH];
	logic [tts_pkg::CELL_W-1:0]  hist_mem [tts_pkg::HIST_DEPTH];
	logic                        scr_we, scr_re, hist_we, hist_re;
	logic [tts_pkg::SCR_AW-1:0]  scr_waddr, scr_raddr;
	logic [tts_pkg::HIST_AW-1:0] hist_waddr, hist_raddr;
	logic [tts_pkg::CELL_W-1:0]  scr_wdata, hist_wdata, scr_rdata, hist_rdata;

	logic [tts_pkg::ROW_W-1:0]  tr_clamp;
	logic [tts_pkg::COL_W-1:0]  tc_clamp;
	logic [tts_pkg::CNT_W-1:0]  sb_min;
	logic                       accept;

	assign accept = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign tr_clamp = (int'(cmd.target_row) >= H) ? tts_pkg::ROW_W'(H - 1) : cmd.target_row;
	assign tc_clamp = (int'(cmd.target_column) >= W) ?
		tts_pkg::COL_W'(W - 1) : cmd.target_column;
	assign sb_min = (sb_q < hcnt_q) ? sb_q : hcnt_q;

	assign rsp.valid = rsp_valid_q;
	assign rsp.cursor_row = rsp_row_q;
	assign rsp.cursor_column = rsp_col_q;
	assign rsp.view_offset = rsp_off_q;
	assign rsp.cell_value = rsp_cell_q;

	// memory port decode
	always_comb begin
		scr_we = 1'b0;
		scr_re = 1'b0;
		scr_waddr = '0;
		scr_raddr = '0;
		scr_wdata = '0;
		hist_we = 1'b0;
		hist_re = 1'b0;
		hist_waddr = '0;
		hist_raddr = '0;
		hist_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				scr_we = 1'b1;
				scr_waddr = idx_q;
				scr_wdata = tts_pkg::CELL_RESET;
			end
			S_OVR: begin
				scr_we = 1'b1;
				scr_waddr = tts_pkg::scr_addr(cur_row_q, cur_col_q);
				scr_wdata = {color_q, c_q};
			end
			S_INS_PEEK: begin
				scr_re = 1'b1;
				scr_raddr = tts_pkg::scr_addr(y_q, tts_pkg::COL_W'(W - 1));
			end
			S_INS_RD: begin
				if (i_q > x_q) begin
					scr_re = 1'b1;
					scr_raddr = tts_pkg::scr_addr(y_q, i_q - 1'b1);
				end else begin
					scr_we = 1'b1;
					scr_waddr = tts_pkg::scr_addr(y_q, x_q);
					scr_wdata = {color_q, c_q};
				end
			end
			S_INS_WR: begin
				scr_we = 1'b1;
				scr_waddr = tts_pkg::scr_addr(y_q, i_q);
				scr_wdata = scr_rdata;
			end
			S_HIST_RD: begin
				scr_re = 1'b1;
				scr_raddr = idx_q;
			end
			S_HIST_WR: begin
				hist_we = 1'b1;
				hist_waddr = tts_pkg::hist_addr(tts_pkg::MOD_W'(hwl_q),
					tts_pkg::COL_W'(idx_q));
				hist_wdata = scr_rdata;
			end
			S_MV_RD: begin
				scr_re = 1'b1;
				scr_raddr = idx_q + tts_pkg::SCR_AW'(W);
			end
			S_MV_WR: begin
				scr_we = 1'b1;
				scr_waddr = idx_q;
				scr_wdata = scr_rdata;
			end
			S_BLANK: begin
				scr_we = 1'b1;
				scr_waddr = idx_q;
				scr_wdata = {color_q, tts_pkg::CH_BLANK};
			end
			S_DEL_RD: begin
				if (int'(i_q) < W - 1) begin
					scr_re = 1'b1;
					scr_raddr = tts_pkg::scr_addr(cur_row_q, i_q + 1'b1);
				end else begin
					scr_we = 1'b1;
					scr_waddr = tts_pkg::scr_addr(cur_row_q, tts_pkg::COL_W'(W - 1));
					scr_wdata = {color_q, tts_pkg::CH_BLANK};
				end
			end
			S_DEL_WR: begin
				scr_we = 1'b1;
				scr_waddr = tts_pkg::scr_addr(cur_row_q, i_q);
				scr_wdata = scr_rdata;
			end
			S_RD_SEL: begin
				if (int'(tr_q) >= int'(k_q)) begin
					scr_re = 1'b1;
					scr_raddr = tts_pkg::scr_addr(
						tts_pkg::ROW_W'(int'(tr_q) - int'(k_q)), tc_q);
				end
			end
			S_RD_MOD: begin
				if (int'(mod_q) < HL) begin
					hist_re = 1'b1;
					hist_raddr = tts_pkg::hist_addr(mod_q, tc_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (scr_we)
			scr_mem[scr_waddr] <= scr_wdata;
		if (scr_re)
			scr_rdata <= scr_mem[scr_raddr];
	end

	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[hist_waddr] <= hist_wdata;
		if (hist_re)
			hist_rdata <= hist_mem[hist_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cur_row_q <= '0;
			cur_col_q <= '0;
			sb_q <= '0;
			hcnt_q <= '0;
			hwl_q <= '0;
			color_q <= tts_pkg::COLOR_RESET;
			idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				color_q <= cfg_wdata;
			if (rsp_valid_q && rsp.ready)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (int'(idx_q) == tts_pkg::SCR_DEPTH - 1) begin
						idx_q <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cell_q <= '0;
						tr_q <= tr_clamp;
						tc_q <= tc_clamp;
						c_q <= cmd.ch;
						idx_q <= '0;
						state_q <= S_DONE;
						case (cmd.op)
							tts_pkg::OP_PUT: begin
								if (cmd.ch == tts_pkg::CH_NEWLINE) begin
									cur_col_q <= '0;
									if (int'(cur_row_q) == H - 1)
										state_q <= S_HIST_RD;
									else
										cur_row_q <= cur_row_q + 1'b1;
								end else if (cmd.ch == tts_pkg::CH_RETURN) begin
									cur_col_q <= '0;
								end else begin
									x_q <= cur_col_q;
									y_q <= cur_row_q;
									state_q <= S_INS_PEEK;
								end
							end
							tts_pkg::OP_OVERWRITE: state_q <= S_OVR;
							tts_pkg::OP_DELETE: begin
								i_q <= cur_col_q;
								state_q <= S_DEL_RD;
							end
							tts_pkg::OP_MOVE: begin
								cur_row_q <= tr_clamp;
								cur_col_q <= tc_clamp;
							end
							tts_pkg::OP_LEFT: begin
								if (sb_q == '0) begin
									if (cur_col_q != '0) begin
										cur_col_q <= cur_col_q - 1'b1;
									end else if (cur_row_q != '0) begin
										cur_row_q <= cur_row_q - 1'b1;
										cur_col_q <= tts_pkg::COL_W'(W - 1);
									end
								end
							end
							tts_pkg::OP_RIGHT: begin
								if (sb_q == '0) begin
									if (int'(cur_col_q) < W - 1) begin
										cur_col_q <= cur_col_q + 1'b1;
									end else if (int'(cur_row_q) < H - 1) begin
										cur_row_q <= cur_row_q + 1'b1;
										cur_col_q <= '0;
									end
								end
							end
							tts_pkg::OP_SCROLL_UP: begin
								if (sb_q < hcnt_q)
									sb_q <= sb_q + 1'b1;
							end
							tts_pkg::OP_SCROLL_DN: begin
								if (sb_q != '0)
									sb_q <= sb_q - 1'b1;
							end
							tts_pkg::OP_READ: state_q <= S_RD_K;
							default: begin
							end
						endcase
					end
				end
				S_OVR: state_q <= S_DONE;
				S_INS_PEEK: state_q <= S_INS_CAP;
				S_INS_CAP: begin
					pushed_q <= scr_rdata[tts_pkg::CHAR_W-1:0];
					i_q <= tts_pkg::COL_W'(W - 1);
					state_q <= S_INS_RD;
				end
				S_INS_RD: begin
					if (i_q > x_q) begin
						state_q <= S_INS_WR;
					end else if (pushed_q == tts_pkg::CH_BLANK || int'(y_q) == H - 1) begin
						state_q <= S_ADV;
					end else begin
						// carry the pushed-off character into the next row
						c_q <= pushed_q;
						x_q <= '0;
						y_q <= y_q + 1'b1;
						state_q <= S_INS_PEEK;
					end
				end
				S_INS_WR: begin
					i_q <= i_q - 1'b1;
					state_q <= S_INS_RD;
				end
				S_ADV: begin
					idx_q <= '0;
					state_q <= S_DONE;
					if (int'(cur_col_q) == W - 1) begin
						cur_col_q <= '0;
						if (int'(cur_row_q) == H - 1)
							state_q <= S_HIST_RD;
						else
							cur_row_q <= cur_row_q + 1'b1;
					end else begin
						cur_col_q <= cur_col_q + 1'b1;
					end
				end
				S_HIST_RD: state_q <= S_HIST_WR;
				S_HIST_WR: begin
					if (int'(idx_q) == W - 1) begin
						idx_q <= '0;
						state_q <= S_MV_RD;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_HIST_RD;
					end
				end
				S_MV_RD: state_q <= S_MV_WR;
				S_MV_WR: begin
					idx_q <= idx_q + 1'b1;
					if (int'(idx_q) == W * (H - 1) - 1)
						state_q <= S_BLANK;
					else
						state_q <= S_MV_RD;
				end
				S_BLANK: begin
					if (int'(idx_q) == tts_pkg::SCR_DEPTH - 1) begin
						hwl_q <= (int'(hwl_q) == HL - 1) ? '0 : hwl_q + 1'b1;
						if (int'(hcnt_q) < HL)
							hcnt_q <= hcnt_q + 1'b1;
						sb_q <= '0;
						cur_row_q <= tts_pkg::ROW_W'(H - 1);
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_DEL_RD: begin
					if (int'(i_q) < W - 1)
						state_q <= S_DEL_WR;
					else
						state_q <= S_DONE;
				end
				S_DEL_WR: begin
					i_q <= i_q + 1'b1;
					state_q <= S_DEL_RD;
				end
				S_RD_K: begin
					k_q <= (int'(sb_min) > H) ? tts_pkg::CNT_W'(H) : sb_min;
					state_q <= S_RD_START;
				end
				S_RD_START: begin
					if (int'(hcnt_q) < HL)
						start_q <= (k_q <= hwl_q) ? hwl_q - k_q : '0;
					else if (int'(hwl_q) >= int'(k_q))
						start_q <= hwl_q - k_q;
					else
						start_q <= tts_pkg::CNT_W'(int'(hwl_q) + HL - int'(k_q));
					state_q <= S_RD_SEL;
				end
				S_RD_SEL: begin
					if (int'(tr_q) < int'(k_q)) begin
						mod_q <= tts_pkg::MOD_W'(int'(start_q) + int'(tr_q));
						rd_hist_q <= 1'b1;
						state_q <= S_RD_MOD;
					end else begin
						rd_hist_q <= 1'b0;
						state_q <= S_RD_WAIT;
					end
				end
				S_RD_MOD: begin
					// wrap the ring line one subtract a cycle
					if (int'(mod_q) >= HL)
						mod_q <= tts_pkg::MOD_W'(int'(mod_q) - HL);
					else
						state_q <= S_RD_WAIT;
				end
				S_RD_WAIT: begin
					cell_q <= rd_hist_q ? hist_rdata : scr_rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_row_q <= cur_row_q;
						rsp_col_q <= cur_col_q;
						rsp_off_q <= tts_pkg::OFF_W'(sb_q);
						rsp_cell_q <= cell_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/tts_checker.sv
// Port-level checker for the text terminal core, bound to the core module.
// Depends on tts_pkg and text_terminal_with_scrollback_core_macros.svh.
`default_nettype none
`include "text_terminal_with_scrollback_core_macros.svh"
module tts_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       cmd_valid,
	input wire logic                       cmd_ready,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [tts_pkg::ROW_W-1:0]  cursor_row,
	input wire logic [tts_pkg::COL_W-1:0]  cursor_column,
	input wire logic [tts_pkg::OFF_W-1:0]  view_offset,
	input wire logic [tts_pkg::CELL_W-1:0] cell_value
);

	`TTS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(cell_value) && $stable(cursor_row) && $stable(cursor_column), "response word changed while stalled")
	`TTS_ASSERT_IMPL(a_cursor_range, rsp_valid, int'(cursor_row) < tts_pkg::SCREEN_HEIGHT && int'(cursor_column) < tts_pkg::SCREEN_WIDTH, "cursor outside the screen")
	`TTS_ASSERT_IMPL(a_offset_range, rsp_valid, int'(view_offset) <= tts_pkg::HISTORY_LINES, "view offset beyond ring depth")
	`TTS_ASSERT_NEXT(a_one_cmd, cmd_valid && cmd_ready, !cmd_ready, "second command taken before the first finished")

endmodule

bind text_terminal_with_scrollback_core tts_checker u_tts_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd_valid(cmd.valid),
	.cmd_ready(cmd.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.cursor_row(rsp.cursor_row),
	.cursor_column(rsp.cursor_column),
	.view_offset(rsp.view_offset),
	.cell_value(rsp.cell_value)
);
`default_nettype wire
